>>> rtl/rirc_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the response checker.
`timescale 1ns / 1ps
`default_nettype none

package rirc_pkg;

	// Register map
	localparam int  RegCount = 1;
	localparam logic [0:0] REG_BYTE_COUNT_LIMIT = 1'b0;
	localparam logic [7:0] LIMIT_RESET = 8'd250;

	// Frame layout
	localparam logic [8:0] HEADER_LEN = 9'd3;
	localparam logic [8:0] POS_SLAVE  = 9'd0;
	localparam logic [8:0] POS_FUNC   = 9'd1;

	// CRC-16/MODBUS
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Result kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// One result beat
	typedef struct packed {
		logic        result_kind;
		logic [7:0]  coil_byte;
		logic [10:0] coil_base;
		logic [7:0]  slave_addr;
		logic [7:0]  func_code;
		logic [7:0]  data_count;
		logic        crc_ok;
		logic        count_ok;
		logic        frame_last;
	} res_t;

	// Fold one byte into the reflected CRC, one bit a step
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> rtl/rirc_frame.sv
// Input register and frame tracking: header capture, CRC and result formation.
`timescale 1ns / 1ps
`default_nettype none

module rirc_frame
	import rirc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       frame_start,
	input  wire logic [7:0] byte_count_limit,
	output logic            res_valid,
	input  wire logic       res_ready,
	output res_t            res
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	logic        in_frame_q;
	logic [8:0]  pos_q;
	logic [15:0] crc_q;
	logic [7:0]  slave_q;
	logic [7:0]  func_q;
	logic [7:0]  count_q;
	logic [7:0]  crc_lo_q;

	logic        advance;
	logic        active;
	logic [8:0]  pos;
	logic [15:0] crc_base;
	logic [15:0] crc_next;
	logic [8:0]  data_end;
	logic        is_header;
	logic        is_data;
	logic        is_crc_lo;
	logic        is_close;
	logic [8:0]  data_idx;

	assign advance  = valid_s1 && res_ready;
	assign in_ready = !valid_s1 || res_ready;

	// Hold the input beat until the result side can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
	end

	// Classify the byte by its place in the frame
	always_comb begin
		active    = start_s1 || in_frame_q;
		pos       = start_s1 ? 9'd0 : pos_q;
		crc_base  = start_s1 ? CRC_INIT : crc_q;
		crc_next  = crc_update(crc_base, byte_s1);
		data_end  = HEADER_LEN + {1'b0, count_q};
		is_header = active && (pos < HEADER_LEN);
		is_data   = active && !is_header && (pos < data_end);
		is_crc_lo = active && !is_header && (pos == data_end);
		is_close  = active && !is_header && (pos > data_end);
		data_idx  = pos - HEADER_LEN;
	end

	// Form the result beat
	always_comb begin
		res             = '0;
		res.slave_addr  = slave_q;
		res.func_code   = func_q;
		res.data_count  = count_q;
		if (is_close) begin
			res.result_kind = KIND_STATUS;
			res.frame_last  = 1'b1;
			res.crc_ok      = ({byte_s1, crc_lo_q} == crc_q);
			res.count_ok    = (count_q <= byte_count_limit);
		end else begin
			res.result_kind = KIND_DATA;
			res.coil_byte   = byte_s1;
			res.coil_base   = {data_idx[7:0], 3'b000};
		end
	end

	assign res_valid = valid_s1 && (is_data || is_close);

	// Advance the frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			crc_q      <= CRC_INIT;
			slave_q    <= '0;
			func_q     <= '0;
			count_q    <= '0;
			crc_lo_q   <= '0;
		end else if (advance && active) begin
			pos_q      <= pos + 9'd1;
			in_frame_q <= !is_close;
			if (is_header || is_data) begin
				crc_q <= crc_next;
			end else if (start_s1) begin
				crc_q <= CRC_INIT;
			end
			if (is_header) begin
				if (pos == POS_SLAVE) begin
					slave_q <= byte_s1;
				end else if (pos == POS_FUNC) begin
					func_q <= byte_s1;
				end else begin
					count_q <= byte_s1;
				end
			end
			if (is_crc_lo) begin
				crc_lo_q <= byte_s1;
			end
		end
	end

	// A frame never runs past its second CRC byte
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (pos_q <= HEADER_LEN + {1'b0, count_q} + 9'd1))
		else $error("frame position beyond frame length");

	// The closing beat leaves the frame
	a_close_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_close) |=> !in_frame_q)
		else $error("frame still open after status beat");

	// Status and last travel together
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.frame_last == (res.result_kind == KIND_STATUS)))
		else $error("last flag does not match result kind");

	// Data beats carry no check flags
	a_data_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.result_kind == KIND_DATA) |-> (!res.crc_ok && !res.count_ok))
		else $error("check flags set on data beat");

endmodule

`default_nettype wire

>>> rtl/rirc_out_buf.sv
// Output register with a skid stage for the result stream.
`timescale 1ns / 1ps
`default_nettype none

module rirc_out_buf
	import rirc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire res_t in_res,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_res
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_q;
	res_t skid_q;
	logic push;

	assign in_ready  = !skid_valid_q;
	assign push      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// Refill the output from the skid first, park a beat when stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= in_res;
			end
		end else if (push) begin
			skid_q <= in_res;
		end
	end

endmodule

`default_nettype wire

>>> rtl/read_inputs_response_checker.sv
// Top level of the read-discrete-inputs response checker: APB register and stream ports.
//
// channel  | signals                        | beat
// ---------+--------------------------------+--------------------------------------
// s_axis   | s_tvalid s_tready s_tdata/user | one frame byte, tuser = frame start
// m_axis   | m_tvalid m_tready m_tdata/user | one coil byte or the end-of-frame status
// apb      | psel penable pwrite paddr ...  | byte_count_limit at address 0
//
// One byte is taken every cycle while s_tready is high; a result passes the input register
// and then the output register before it leaves.
// A stall on m_tready with a result waiting fills the skid stage; s_tready then stays
// low while the skid stage is full and a byte waits; header and CRC bytes wait as well.
// Reset clears the frame state and sets the limit to 250.
`timescale 1ns / 1ps
`default_nettype none

module read_inputs_response_checker
	import rirc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// s_tdata: rx_byte[7:0]
	// s_tuser: frame_start[0]
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,
	input  wire logic [0:0]  s_tuser,
	// m_tdata: coil_byte[7:0], coil_base[18:8], slave_addr[26:19], func_code[34:27],
	//          data_count[42:35], crc_ok[43], count_ok[44], zero fill[47:45]
	// m_tuser: result_kind[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,
	output logic [0:0]       m_tuser,
	output logic             m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [7:0] limit_q;
	logic [0:0] reg_idx;
	logic       res_valid;
	logic       res_ready;
	res_t       res;
	res_t       out_res;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2:2];

	// Write the limit register on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_BYTE_COUNT_LIMIT) begin
			limit_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_BYTE_COUNT_LIMIT) begin
			prdata = {24'h000000, limit_q};
		end
	end

	rirc_frame u_frame (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_tvalid),
		.in_ready         (s_tready),
		.rx_byte          (s_tdata),
		.frame_start      (s_tuser[0]),
		.byte_count_limit (limit_q),
		.res_valid        (res_valid),
		.res_ready        (res_ready),
		.res              (res)
	);

	rirc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_res    (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// Pack the result beat
	assign m_tdata = {3'b000, out_res.count_ok, out_res.crc_ok, out_res.data_count,
		out_res.func_code, out_res.slave_addr, out_res.coil_base, out_res.coil_byte};
	assign m_tuser = out_res.result_kind;
	assign m_tlast = out_res.frame_last;

endmodule

`default_nettype wire

>>> tb/sv/rirc_frame_monitor.sv
// Watches the frame, result and register channels, predicts every result beat and compares.
`timescale 1ns / 1ps

module rirc_frame_monitor
	import rirc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,    // rx_byte[7:0]
	input  wire logic [0:0]  s_tuser,    // frame_start[0]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [47:0] m_tdata,    // coil_byte, coil_base, slave_addr, func_code,
	                                     // data_count, crc_ok, count_ok, zero fill
	input  wire logic [0:0]  m_tuser,    // result_kind[0]
	input  wire logic        m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               fail_count,
	output int               expected_left
);

	localparam logic [2:0] LIMIT_ADDR = {REG_BYTE_COUNT_LIMIT, 2'b00};

	// Shadow of the register and of the frame tracker
	logic [7:0]  cfg_limit;
	logic        in_frame;
	logic [8:0]  byte_pos;
	logic [15:0] crc_acc;
	logic [7:0]  held_slave;
	logic [7:0]  held_func;
	logic [7:0]  held_count;
	logic [7:0]  crc_lo;

	// Result beats owed by the block, oldest first
	res_t due_beats[$];

	// Reflected CRC-16, one input bit per shift
	function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = acc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c  = {1'b0, c[15:1]};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// Advance the frame tracker by one accepted byte and queue any result it owes
	task automatic track_byte(input logic [7:0] b, input logic st);
		res_t       r;
		logic [8:0] pos;
		logic [9:0] data_end;
		if (st) begin
			in_frame = 1'b1;
			byte_pos = '0;
			crc_acc  = CRC_INIT;
		end else if (!in_frame) begin
			return;
		end
		pos      = byte_pos;
		byte_pos = pos + 9'd1;

		// header: capture and fold into the CRC
		if (pos < HEADER_LEN) begin
			if (pos == POS_SLAVE) begin
				held_slave = b;
			end else if (pos == POS_FUNC) begin
				held_func = b;
			end else begin
				held_count = b;
			end
			crc_acc = crc16_fold(crc_acc, b);
			return;
		end

		r            = '0;
		r.slave_addr = held_slave;
		r.func_code  = held_func;
		r.data_count = held_count;
		data_end     = 10'(HEADER_LEN) + 10'(held_count);

		if (10'(pos) < data_end) begin
			crc_acc       = crc16_fold(crc_acc, b);
			r.result_kind = KIND_DATA;
			r.coil_byte   = b;
			r.coil_base   = {pos[7:0] - 8'(HEADER_LEN), 3'b000};
			due_beats.push_back(r);
		end else if (10'(pos) == data_end) begin
			crc_lo = b;
		end else begin
			// second CRC byte closes the frame
			in_frame      = 1'b0;
			r.result_kind = KIND_STATUS;
			r.crc_ok      = ({b, crc_lo} == crc_acc);
			r.count_ok    = (held_count <= cfg_limit);
			r.frame_last  = 1'b1;
			due_beats.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input logic [10:0] want, input logic [10:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Compare one result beat with the oldest owed one
	task automatic compare_beat();
		res_t want;
		if (due_beats.size() == 0) begin
			$error("result beat with nothing due: tdata %h tuser %b tlast %b",
				m_tdata, m_tuser, m_tlast);
			fail_count++;
			return;
		end
		want = due_beats.pop_front();
		check_field("result_kind", 11'(want.result_kind), 11'(m_tuser[0]));
		check_field("coil_byte",   11'(want.coil_byte),   11'(m_tdata[7:0]));
		check_field("coil_base",   want.coil_base,        m_tdata[18:8]);
		check_field("slave_addr",  11'(want.slave_addr),  11'(m_tdata[26:19]));
		check_field("func_code",   11'(want.func_code),   11'(m_tdata[34:27]));
		check_field("data_count",  11'(want.data_count),  11'(m_tdata[42:35]));
		check_field("crc_ok",      11'(want.crc_ok),      11'(m_tdata[43]));
		check_field("count_ok",    11'(want.count_ok),    11'(m_tdata[44]));
		check_field("frame_last",  11'(want.frame_last),  11'(m_tlast));
	endtask

	// Sample every channel at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_limit  = LIMIT_RESET;
			in_frame   = 1'b0;
			byte_pos   = '0;
			crc_acc    = CRC_INIT;
			held_slave = '0;
			held_func  = '0;
			held_count = '0;
			crc_lo     = '0;
			due_beats.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR) begin
				cfg_limit = pwdata[7:0];
			end
			if (s_tvalid && s_tready) begin
				track_byte(s_tdata, s_tuser[0]);
			end
			if (m_tvalid && m_tready) begin
				compare_beat();
			end
		end
		expected_left = due_beats.size();
	end

endmodule

>>> tb/sv/read_inputs_response_checker_tb.sv
// Testbench top: clock, reset, frame stimulus, register writes and the final verdict.
`timescale 1ns / 1ps

module read_inputs_response_checker_tb;
	import rirc_pkg::*;

	localparam logic [2:0] LIMIT_ADDR  = {REG_BYTE_COUNT_LIMIT, 2'b00};
	localparam int         HOLD_CYCLES = 400;
	localparam int         PHASE_BEATS = 190;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int expected_left;

	// Sender pacing and frame build-up
	int         gap_max       = 6;
	int         burst_left    = 0;
	int         frame_beats   = 0;
	int         hold_requests = 0;
	logic [7:0] frame_q[$];

	always #4 clk = ~clk;

	read_inputs_response_checker u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	rirc_frame_monitor u_mon (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.fail_count    (fail_count),
		.expected_left (expected_left)
	);

	// Offer one byte beat, opening a random gap at the end of each burst
	task automatic push_beat(input logic [7:0] b, input logic st);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(gap_max, 0);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(12, 1);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= st;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Build a frame: header then random data bytes
	task automatic make_frame(input logic [7:0] slave, input logic [7:0] func,
		input logic [7:0] cnt);
		frame_q = {slave, func, cnt};
		repeat (cnt) frame_q.push_back(8'($urandom));
	endtask

	// Append the CRC, low byte first, and send the frame or its first keep bytes
	task automatic send_frame(input bit bad_crc, input int keep);
		logic [15:0] crc;
		int          last;
		crc = CRC_INIT;
		foreach (frame_q[i]) crc = crc_update(crc, frame_q[i]);
		if (bad_crc) begin
			crc = crc ^ (16'd1 << $urandom_range(15, 0));
		end
		frame_q.push_back(crc[7:0]);
		frame_q.push_back(crc[15:8]);
		last = (keep == 0) ? frame_q.size() : keep;
		for (int i = 0; i < last; i++) begin
			push_beat(frame_q[i], i == 0);
			frame_beats++;
		end
	endtask

	// Mostly clean frames, some with bad CRC, some cut short, some loose bytes
	task automatic random_frame();
		int         pick;
		int         n;
		logic [7:0] cnt;
		logic [7:0] fc;
		pick = $urandom_range(99, 0);
		if (pick >= 88) begin
			n = $urandom_range(6, 1);
			repeat (n) push_beat(8'($urandom), (pick >= 95) ? 1'($urandom) : 1'b0);
			return;
		end
		cnt = ($urandom_range(99, 0) < 2) ? 8'($urandom_range(255, 128))
			: 8'($urandom_range(8, 0));
		fc  = ($urandom_range(4, 0) == 0) ? 8'($urandom) : 8'h02;
		make_frame(8'($urandom), fc, cnt);
		if (pick < 70) begin
			send_frame(1'b0, 0);
		end else if (pick < 80) begin
			send_frame(1'b1, 0);
		end else begin
			send_frame(1'b0, $urandom_range(frame_q.size() + 1, 1));
		end
	endtask

	// Drop valid and wait until every owed result has left, plus pipeline slack
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (expected_left == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] lim);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LIMIT_ADDR;
		pwdata  <= {24'($urandom), lim};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Receiver: stall pattern of its own, plus long hold-offs on request
	initial begin : receiver
		int run_left;
		int mode;
		int hold_served;
		run_left    = 0;
		mode        = 0;
		hold_served = 0;
		m_tready    = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served < hold_requests) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_served++;
			end
			if (run_left == 0) begin
				mode     = $urandom_range(2, 0);
				run_left = $urandom_range(40, 1);
			end
			run_left--;
			case (mode)
				0: begin
					m_tready <= 1'b1;
				end
				1: begin
					m_tready <= 1'($urandom);
				end
				default: begin
					m_tready <= ($urandom_range(3, 0) == 0);
				end
			endcase
		end
	end

	// Stimulus and verdict
	initial begin : stimulus
		logic [7:0] limit_plan [5];
		int         target;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		limit_plan = '{8'd0, 8'd255, 8'($urandom), 8'd4, 8'd1};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stray byte, empty frame, extreme header and data, bad CRC,
		// restart during a frame, all under the reset limit
		push_beat(8'hA5, 1'b0);
		make_frame(8'h00, 8'h02, 8'd0);
		send_frame(1'b0, 0);
		make_frame(8'hFF, 8'hFF, 8'd2);
		frame_q[3] = 8'h00;
		frame_q[4] = 8'hFF;
		send_frame(1'b0, 0);
		make_frame(8'h01, 8'h00, 8'd1);
		send_frame(1'b1, 0);
		make_frame(8'h07, 8'h02, 8'd3);
		send_frame(1'b0, 4);
		make_frame(8'h08, 8'h02, 8'd1);
		send_frame(1'b0, 0);
		drain();

		// random phases, each under its own limit
		target = frame_beats;
		for (int p = 0; p < 5; p++) begin
			write_limit(limit_plan[p]);
			gap_max = (p % 2 == 0) ? 0 : 6;
			target += PHASE_BEATS;
			if (p == 1) begin
				// largest count: top coil base and count at the limit
				make_frame(8'($urandom), 8'h02, 8'd255);
				send_frame(1'b0, 0);
			end
			if (p == 2) begin
				// hold the receiver off while a long frame keeps coming
				hold_requests++;
				make_frame(8'h11, 8'h02, 8'd48);
				send_frame(1'b0, 0);
			end
			while (frame_beats < target) random_frame();
			// close the phase on a complete frame
			make_frame(8'($urandom), 8'h02, 8'($urandom_range(4, 0)));
			send_frame(1'b0, 0);
			drain();
		end

		if (fail_count == 0 && expected_left == 0) begin
			$display("read_inputs_response_checker test passed");
		end else begin
			$display("read_inputs_response_checker test failed");
		end
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#5_000_000;
		$display("read_inputs_response_checker test failed");
		$finish;
	end

endmodule
